// ===== hdl/scrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrs_pkg
// Shared constants, types and register tables of the configuration space.
// ----------------------------------------------------------------------------
package scrs_pkg;

  localparam int NUM_DEVICES     = 12;
  localparam int NUM_GLOBAL_REGS = 48;
  localparam int DEV_W           = $clog2(NUM_DEVICES);
  localparam int SLOT_W          = 5;
  localparam int MEM_AW          = DEV_W + SLOT_W;
  localparam int MEM_DEPTH       = NUM_DEVICES * (2 ** SLOT_W);
  localparam int NUM_GSLOTS      = 10;
  localparam int GSLOT_W         = $clog2(NUM_GSLOTS);

  localparam logic [7:0] UNLOCK_KEY  = 8'h87;
  localparam logic [7:0] IDX_SWRESET = 8'h02;
  localparam logic [7:0] IDX_DEVSEL  = 8'h07;
  localparam logic [7:0] IDX_ID_HI   = 8'h20;
  localparam logic [7:0] IDX_ID_LO   = 8'h21;
  localparam logic [7:0] ID_HI_VAL   = 8'h52;
  localparam logic [7:0] ID_LO_VAL   = 8'h17;
  localparam logic [7:0] FIRST_DEV   = 8'h30;
  localparam logic [7:0] NO_DEV_VAL  = 8'hff;

  typedef struct packed {
    logic              accept;
    logic              exec;
    logic              clr_we;
    logic [MEM_AW-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic sw_reset;
  } sts_t;

  // bit 5: in device set, [4:0]: slot
  function automatic logic [SLOT_W:0] dev_slot(input logic [7:0] r);
    logic [SLOT_W:0] s;
    s = '0;
    if (r == 8'h30) s = {1'b1, 5'd0};
    else if (r >= 8'h60 && r <= 8'h63) s = {1'b1, 5'(r - 8'h5f)};
    else if (r == 8'h70) s = {1'b1, 5'd5};
    else if (r == 8'h72) s = {1'b1, 5'd6};
    else if (r == 8'h74) s = {1'b1, 5'd7};
    else if (r >= 8'he0 && r <= 8'he7) s = {1'b1, 5'(r - 8'hd8)};
    else if (r >= 8'hf0 && r <= 8'hf6) s = {1'b1, 5'(r - 8'he0)};
    return s;
  endfunction

  function automatic logic [7:0] slot_reg(input logic [SLOT_W-1:0] s);
    logic [7:0] r;
    r = 8'h00;
    if (s == 5'd0) r = 8'h30;
    else if (s <= 5'd4) r = 8'(8'h5f + 8'(s));
    else if (s == 5'd5) r = 8'h70;
    else if (s == 5'd6) r = 8'h72;
    else if (s == 5'd7) r = 8'h74;
    else if (s <= 5'd15) r = 8'(8'hd8 + 8'(s));
    else if (s <= 5'd22) r = 8'(8'he0 + 8'(s));
    return r;
  endfunction

  function automatic logic [7:0] dev_default(input logic [DEV_W-1:0] d, input logic [7:0] r);
    logic [7:0] v;
    v = 8'h00;
    unique case (d)
      4'd0: begin
        unique case (r)
          8'h30: v = 8'h01; 8'h60: v = 8'h03; 8'h61: v = 8'hf0; 8'h70: v = 8'h06;
          8'h74: v = 8'h02; 8'hf0: v = 8'h0e; 8'hf2: v = 8'hff;
          default: v = 8'h00;
        endcase
      end
      4'd1: begin
        unique case (r)
          8'h30: v = 8'h01; 8'h60: v = 8'h03; 8'h61: v = 8'h78; 8'h70: v = 8'h07;
          8'h74: v = 8'h04; 8'hf0: v = 8'h3f;
          default: v = 8'h00;
        endcase
      end
      4'd2, 4'd3: begin
        unique case (r)
          8'h30: v = 8'h01; 8'h60: v = (d == 4'd2) ? 8'h03 : 8'h02; 8'h61: v = 8'hf8;
          8'h70: v = (d == 4'd2) ? 8'h04 : 8'h03;
          default: v = 8'h00;
        endcase
      end
      4'd5: begin
        unique case (r)
          8'h30: v = 8'h01; 8'h61: v = 8'h60; 8'h63: v = 8'h64; 8'h70: v = 8'h01;
          8'h72: v = 8'h0c; 8'hf0: v = 8'h80;
          default: v = 8'h00;
        endcase
      end
      4'd6: v = (r == 8'h30) ? 8'h01 : 8'h00;
      4'd7: begin
        unique case (r)
          8'h60: v = 8'h02; 8'h61: v = 8'h01; 8'h62: v = 8'h03; 8'h63: v = 8'h30;
          8'h70: v = 8'h09; 8'hf0: v = 8'hff;
          default: v = 8'h00;
        endcase
      end
      4'd9: v = (r == 8'hf0) ? 8'hff : 8'h00;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // bit 8: write-AND
  function automatic logic [8:0] dev_mask(input logic [DEV_W-1:0] d, input logic [7:0] r);
    logic [8:0] m;
    m = '0;
    if (r == 8'h30) begin
      m = (d == 4'd7) ? 9'h007 : (d == 4'd4 || d > 4'd11) ? 9'h000 : 9'h001;
    end else begin
      unique case (d)
        4'd0: begin
          if (r == 8'h60 || r == 8'h61 || (r >= 8'hf0 && r <= 8'hf2)) m = 9'h0ff;
          else if (r == 8'h70) m = 9'h00f;
          else if (r == 8'h74) m = 9'h007;
          else if (r == 8'hf4 || r == 8'hf5) m = 9'h05b;
        end
        4'd1: begin
          if (r == 8'h60 || r == 8'h61) m = 9'h0ff;
          else if (r == 8'h70) m = 9'h00f;
          else if (r == 8'hf0) m = 9'h07f;
        end
        4'd2, 4'd3: begin
          if (r == 8'h60 || r == 8'h61) m = 9'h0ff;
          else if (r == 8'h70) m = 9'h00f;
          else if (r == 8'hf0) m = 9'h003;
          else if (r == 8'hf1 && d == 4'd3) m = 9'h07f;
        end
        4'd5: begin
          if (r >= 8'h60 && r <= 8'h63) m = 9'h0ff;
          else if (r == 8'h70 || r == 8'h72) m = 9'h00f;
          else if (r == 8'hf0) m = 9'h0c7;
        end
        4'd6: begin
          if (r == 8'h60 || r == 8'h61) m = 9'h0ff;
          else if (r == 8'h70) m = 9'h00f;
        end
        4'd7: begin
          if ((r >= 8'h60 && r <= 8'h63) || (r >= 8'hf0 && r <= 8'hf2)) m = 9'h0ff;
          else if (r == 8'h70) m = 9'h00f;
        end
        4'd8: begin
          if ((r >= 8'hf0 && r <= 8'hf2) || r == 8'hf6) m = 9'h0ff;
          else if (r == 8'hf5) m = 9'h0cc;
        end
        4'd9: begin
          if (r >= 8'hf0 && r <= 8'hf2) m = 9'h0ff;
          else if (r == 8'hf3) m = 9'h0c0;
        end
        4'd10: begin
          if (r == 8'h70 || r == 8'he7) m = 9'h00f;
          else if (r == 8'he0) m = 9'h0c0;
          else if (r == 8'he1 || r == 8'he2 || r == 8'hf0) m = 9'h0ff;
          else if (r == 8'he4) m = 9'h0fc;
          else if (r == 8'he5 || r == 8'he6) m = 9'h07f;
          else if (r == 8'hf1) m = 9'h0ef;
          else if (r == 8'hf3 || r == 8'hf4) m = 9'h13f;
          else if (r == 8'hf5) m = 9'h03f;
        end
        4'd11: begin
          if (r == 8'h70) m = 9'h00f;
          else if (r == 8'hf0) m = 9'h001;
        end
        default: m = '0;
      endcase
    end
    return m;
  endfunction

  // bit 4: writable global, [3:0]: storage slot
  function automatic logic [GSLOT_W:0] glob_slot(input logic [7:0] r);
    logic [GSLOT_W:0] s;
    unique case (r)
      8'h07: s = {1'b1, 4'd0};
      8'h22: s = {1'b1, 4'd1};
      8'h23: s = {1'b1, 4'd2};
      8'h24: s = {1'b1, 4'd3};
      8'h25: s = {1'b1, 4'd4};
      8'h26: s = {1'b1, 4'd5};
      8'h28: s = {1'b1, 4'd6};
      8'h29: s = {1'b1, 4'd7};
      8'h2a: s = {1'b1, 4'd8};
      8'h2b: s = {1'b1, 4'd9};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] glob_mask(input logic [7:0] r);
    logic [7:0] m;
    unique case (r)
      8'h07: m = 8'hff; 8'h22: m = 8'h7f; 8'h23: m = 8'h01; 8'h24: m = 8'hca;
      8'h25: m = 8'h39; 8'h26: m = 8'hef; 8'h28: m = 8'h07; 8'h29: m = 8'hfc;
      8'h2a: m = 8'hff; 8'h2b: m = 8'hff;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/scrs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrs_ctrl
// Sequencer: clearing pass, request accept, execute and result handoff.
// ----------------------------------------------------------------------------
module scrs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  scrs_pkg::sts_t sts_i,
  output scrs_pkg::cmd_t cmd_o
);
  import scrs_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_WAIT} state_e;

  state_e            state_q;
  logic [MEM_AW-1:0] cnt_q;
  logic              out_valid_q;

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign cmd_o.accept    = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.exec      = (state_q == ST_EXEC);
  assign cmd_o.clr_we    = (state_q == ST_CLEAR);
  assign cmd_o.clr_addr  = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == MEM_AW'(MEM_DEPTH - 1)) state_q <= ST_WAIT;
        end
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          out_valid_q <= 1'b1;
          cnt_q       <= '0;
          state_q     <= sts_i.sw_reset ? ST_CLEAR : ST_WAIT;
        end
        ST_WAIT: begin
          if (!out_valid_q || !out_stall_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_exec_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |=> out_valid_q) else $error("result not raised");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && state_q != ST_EXEC |=> out_valid_q)
    else $error("stalled result dropped");
  a_idle_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !out_valid_q) else $error("request taken with result pending");
`endif

endmodule

// ===== hdl/scrs_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrs_dpath
// Index, lock, global registers, device register RAM and result registers.
// ----------------------------------------------------------------------------
module scrs_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  scrs_pkg::cmd_t cmd_i,
  output scrs_pkg::sts_t sts_o,
  input  logic           kind_i,
  input  logic           port_select_i,
  input  logic [7:0]     write_byte_i,
  output logic [7:0]     read_byte_o,
  output logic           unlocked_flag_o
);
  import scrs_pkg::*;

  logic [7:0]        index_q;
  logic              unlocked_q;
  logic              kind_q, port_q;
  logic [7:0]        wbyte_q;
  logic [7:0]        glob_q [NUM_GSLOTS];
  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rdata_q;
  logic [7:0]        rbyte_q;
  logic              unl_out_q;

  logic [7:0]        dev;
  logic              dev_ok;
  logic [SLOT_W:0]   ds;
  logic [GSLOT_W:0]  gs;
  logic [8:0]        dmask;
  logic [MEM_AW-1:0] ra, wa;
  logic [7:0]        wd, dev_wd, rd_val, glob_rd;
  logic              we, dev_we, data_wr, unl_d;
  logic [DEV_W-1:0]  clr_dev;

  assign dev     = glob_q[0];
  assign dev_ok  = (dev < 8'(NUM_DEVICES));
  assign ds      = dev_slot(index_q);
  assign gs      = glob_slot(index_q);
  assign dmask   = dev_mask(dev[DEV_W-1:0], index_q);
  assign ra      = dev_ok ? {dev[DEV_W-1:0], ds[SLOT_W-1:0]} : '0;
  assign data_wr = kind_q && port_q && unlocked_q;
  assign sts_o.sw_reset = data_wr && (index_q == IDX_SWRESET) && wbyte_q[0];

  assign dev_we = cmd_i.exec && data_wr && (index_q >= FIRST_DEV) && ds[SLOT_W] &&
                  dev_ok && (dmask != '0);
  assign dev_wd = dmask[8] ? (rdata_q & wbyte_q & dmask[7:0]) : (wbyte_q & dmask[7:0]);
  assign clr_dev = cmd_i.clr_addr[MEM_AW-1:SLOT_W];
  assign we = cmd_i.clr_we || dev_we;
  assign wa = cmd_i.clr_we ? cmd_i.clr_addr : ra;
  assign wd = cmd_i.clr_we ?
              dev_default(clr_dev, slot_reg(cmd_i.clr_addr[SLOT_W-1:0])) : dev_wd;

  always_comb begin
    if (index_q == IDX_ID_HI) glob_rd = ID_HI_VAL;
    else if (index_q == IDX_ID_LO) glob_rd = ID_LO_VAL;
    else if (gs[GSLOT_W]) glob_rd = glob_q[gs[GSLOT_W-1:0]];
    else glob_rd = 8'h00;
    if (index_q < FIRST_DEV) rd_val = glob_rd;
    else if (!dev_ok) rd_val = NO_DEV_VAL;
    else if (ds[SLOT_W]) rd_val = rdata_q;
    else rd_val = 8'h00;
    unl_d = unlocked_q;
    if (kind_q && !port_q && !unlocked_q)
      unl_d = (wbyte_q == UNLOCK_KEY) && (index_q == UNLOCK_KEY);
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (cmd_i.accept) begin
      rdata_q <= mem[ra];
      kind_q  <= kind_i;
      port_q  <= port_select_i;
      wbyte_q <= write_byte_i;
    end
    if (cmd_i.exec) rbyte_q <= kind_q ? 8'h00 : rd_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q    <= '0;
      unlocked_q <= 1'b0;
      unl_out_q  <= 1'b0;
      for (int i = 0; i < NUM_GSLOTS; i++) glob_q[i] <= '0;
    end else if (cmd_i.exec) begin
      if (sts_o.sw_reset) begin
        unlocked_q <= 1'b0;
        unl_out_q  <= 1'b0;
        for (int i = 0; i < NUM_GSLOTS; i++) glob_q[i] <= '0;
      end else begin
        unlocked_q <= unl_d;
        unl_out_q  <= unl_d;
        if (kind_q && !port_q) index_q <= wbyte_q;
        if (data_wr && gs[GSLOT_W])
          glob_q[gs[GSLOT_W-1:0]] <= wbyte_q & glob_mask(index_q);
      end
    end
  end

  assign read_byte_o     = rbyte_q;
  assign unlocked_flag_o = unl_out_q;

endmodule

// ===== hdl/superio_config_register_space.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// superio_config_register_space
// Index/data port configuration space with unlock key and per-device regs.
// ----------------------------------------------------------------------------
// The sequencer holds one request at a time: it takes no new request until
//   the current one has passed accept with RAM read, execute (which registers
//   the result and raises out_valid) and result handoff.
// Reset: locked, index zero; a clearing pass over all 384 RAM entries loads
//   the device defaults before the first request. A software reset repeats it.
module superio_config_register_space (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic       port_select_i,
  input  logic [7:0] write_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_byte_o,
  output logic       unlocked_flag_o
);
  import scrs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  scrs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  scrs_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .kind_i, .port_select_i,
    .write_byte_i, .read_byte_o, .unlocked_flag_o
  );

endmodule

// ===== tb/sv/scrs_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrs_tb_pkg
// Access codes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package scrs_tb_pkg;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;
  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_DATA  = 1'b1;

  localparam int HOLD_CYCLES = 200;

endpackage

// ===== tb/sv/scrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrs_checker
// Watches both channels, predicts each access result from its own copy of
// the index, lock and register state, and compares results in order.
// ----------------------------------------------------------------------------
module scrs_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       kind_i,
  input  logic       port_select_i,
  input  logic [7:0] write_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] read_byte_i,
  input  logic       unlocked_flag_i,
  output int         errors_o,
  output int         pending_o
);
  import scrs_pkg::*;
  import scrs_tb_pkg::*;

  typedef struct packed {
    logic [7:0] rdata;
    logic       unl;
  } access_result_t;

  access_result_t result_q[$];

  logic [7:0] cur_index;
  logic       cur_unl;
  logic [7:0] glob_r [NUM_GLOBAL_REGS];
  logic [7:0] dev_r  [NUM_DEVICES][256];

  assign pending_o = result_q.size();

  task automatic load_power_on();
    for (int i = 0; i < NUM_GLOBAL_REGS; i++) glob_r[i] = 8'h00;
    for (int d = 0; d < NUM_DEVICES; d++)
      for (int r = 0; r < 256; r++) dev_r[d][r] = 8'h00;
    glob_r[8'h20] = 8'h52;
    glob_r[8'h21] = 8'h17;
    dev_r[0][8'h30] = 8'h01; dev_r[0][8'h60] = 8'h03; dev_r[0][8'h61] = 8'hf0;
    dev_r[0][8'h70] = 8'h06; dev_r[0][8'h74] = 8'h02; dev_r[0][8'hf0] = 8'h0e;
    dev_r[0][8'hf2] = 8'hff;
    dev_r[1][8'h30] = 8'h01; dev_r[1][8'h60] = 8'h03; dev_r[1][8'h61] = 8'h78;
    dev_r[1][8'h70] = 8'h07; dev_r[1][8'h74] = 8'h04; dev_r[1][8'hf0] = 8'h3f;
    dev_r[2][8'h30] = 8'h01; dev_r[2][8'h60] = 8'h03; dev_r[2][8'h61] = 8'hf8;
    dev_r[2][8'h70] = 8'h04;
    dev_r[3][8'h30] = 8'h01; dev_r[3][8'h60] = 8'h02; dev_r[3][8'h61] = 8'hf8;
    dev_r[3][8'h70] = 8'h03;
    dev_r[5][8'h30] = 8'h01; dev_r[5][8'h61] = 8'h60; dev_r[5][8'h63] = 8'h64;
    dev_r[5][8'h70] = 8'h01; dev_r[5][8'h72] = 8'h0c; dev_r[5][8'hf0] = 8'h80;
    dev_r[6][8'h30] = 8'h01;
    dev_r[7][8'h60] = 8'h02; dev_r[7][8'h61] = 8'h01; dev_r[7][8'h62] = 8'h03;
    dev_r[7][8'h63] = 8'h30; dev_r[7][8'h70] = 8'h09; dev_r[7][8'hf0] = 8'hff;
    dev_r[9][8'hf0] = 8'hff;
  endtask

  function automatic logic [7:0] global_wmask(input logic [7:0] r);
    case (r)
      8'h07, 8'h2a, 8'h2b: return 8'hff;
      8'h22: return 8'h7f;
      8'h23: return 8'h01;
      8'h24: return 8'hca;
      8'h25: return 8'h39;
      8'h26: return 8'hef;
      8'h28: return 8'h07;
      8'h29: return 8'hfc;
      default: return 8'h00;
    endcase
  endfunction

  function automatic bit is_dev_index(input logic [7:0] r);
    return r == 8'h30 || (r >= 8'h60 && r <= 8'h63) || r == 8'h70 || r == 8'h72 ||
           r == 8'h74 || (r >= 8'he0 && r <= 8'he7) || (r >= 8'hf0 && r <= 8'hf6);
  endfunction

  // bit 8 flags write-AND
  function automatic logic [8:0] device_wmask(input int d, input logic [7:0] r);
    bit fx;
    fx = (r >= 8'hf0 && r <= 8'hf2);
    if (r == 8'h30) return (d == 7) ? 9'h007 : (d == 4 || d > 11) ? 9'h000 : 9'h001;
    case (d)
      0: begin
        if (r == 8'h60 || r == 8'h61 || fx) return 9'h0ff;
        if (r == 8'h70) return 9'h00f;
        if (r == 8'h74) return 9'h007;
        if (r == 8'hf4 || r == 8'hf5) return 9'h05b;
      end
      1: begin
        if (r == 8'h60 || r == 8'h61) return 9'h0ff;
        if (r == 8'h70) return 9'h00f;
        if (r == 8'hf0) return 9'h07f;
      end
      2, 3: begin
        if (r == 8'h60 || r == 8'h61) return 9'h0ff;
        if (r == 8'h70) return 9'h00f;
        if (r == 8'hf0) return 9'h003;
        if (r == 8'hf1 && d == 3) return 9'h07f;
      end
      5: begin
        if (r >= 8'h60 && r <= 8'h63) return 9'h0ff;
        if (r == 8'h70 || r == 8'h72) return 9'h00f;
        if (r == 8'hf0) return 9'h0c7;
      end
      6: begin
        if (r == 8'h60 || r == 8'h61) return 9'h0ff;
        if (r == 8'h70) return 9'h00f;
      end
      7: begin
        if ((r >= 8'h60 && r <= 8'h63) || fx) return 9'h0ff;
        if (r == 8'h70) return 9'h00f;
      end
      8: begin
        if (fx || r == 8'hf6) return 9'h0ff;
        if (r == 8'hf5) return 9'h0cc;
      end
      9: begin
        if (fx) return 9'h0ff;
        if (r == 8'hf3) return 9'h0c0;
      end
      10: begin
        if (r == 8'h70 || r == 8'he7) return 9'h00f;
        if (r == 8'he0) return 9'h0c0;
        if (r == 8'he1 || r == 8'he2 || r == 8'hf0) return 9'h0ff;
        if (r == 8'he4) return 9'h0fc;
        if (r == 8'he5 || r == 8'he6) return 9'h07f;
        if (r == 8'hf1) return 9'h0ef;
        if (r == 8'hf3 || r == 8'hf4) return 9'h13f;
        if (r == 8'hf5) return 9'h03f;
      end
      11: begin
        if (r == 8'h70) return 9'h00f;
        if (r == 8'hf0) return 9'h001;
      end
      default: ;
    endcase
    return 9'h000;
  endfunction

  task automatic apply_data_write(input logic [7:0] v);
    logic [8:0] m;
    int d;
    d = glob_r[IDX_DEVSEL];
    if (cur_index == IDX_SWRESET) begin
      if (v[0]) begin
        load_power_on();
        cur_unl = 1'b0;
      end
    end else if (cur_index < NUM_GLOBAL_REGS) begin
      glob_r[cur_index] = global_wmask(cur_index) == 8'h00 ? glob_r[cur_index]
                                                           : v & global_wmask(cur_index);
    end else if (is_dev_index(cur_index) && d < NUM_DEVICES) begin
      m = device_wmask(d, cur_index);
      if (m[8]) dev_r[d][cur_index] = dev_r[d][cur_index] & v & m[7:0];
      else if (m != 9'h000) dev_r[d][cur_index] = v & m[7:0];
    end
  endtask

  function automatic logic [7:0] read_selected();
    int d;
    d = glob_r[IDX_DEVSEL];
    if (cur_index < NUM_GLOBAL_REGS) return glob_r[cur_index];
    if (d < NUM_DEVICES) return dev_r[d][cur_index];
    return NO_DEV_VAL;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %02h expected %02h", what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t e;
    access_result_t g;
    if (!rst_ni) begin
      cur_index = 8'h00;
      cur_unl   = 1'b0;
      load_power_on();
      result_q.delete();
      errors_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        g.rdata = read_byte_i;
        g.unl   = unlocked_flag_i;
        if (result_q.size() == 0) begin
          report("unexpected result", int'(g), 0);
        end else begin
          e = result_q.pop_front();
          if (g.rdata !== e.rdata) report("read_byte", g.rdata, e.rdata);
          if (g.unl !== e.unl) report("unlocked_flag", g.unl, e.unl);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        e.rdata = 8'h00;
        if (kind_i == KIND_READ) begin
          e.rdata = read_selected();
        end else if (port_select_i == PORT_INDEX) begin
          if (!cur_unl) cur_unl = (write_byte_i == UNLOCK_KEY && cur_index == UNLOCK_KEY);
          cur_index = write_byte_i;
        end else if (cur_unl) begin
          apply_data_write(write_byte_i);
        end
        e.unl = cur_unl;
        result_q.push_back(e);
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random index/data port requests with random gaps and
// output stalls, including two long output hold-offs; the checker scores them.
// ----------------------------------------------------------------------------
module tb_top;
  import scrs_pkg::*;
  import scrs_tb_pkg::*;

  localparam int NUM_RANDOM = 450;
  localparam int IDLE_LIMIT = 5000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       kind_i = KIND_READ;
  logic       port_select_i = PORT_INDEX;
  logic [7:0] write_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] read_byte_o;
  logic       unlocked_flag_o;
  int         errors;
  int         pending;
  int         idle_cycles = 0;
  int         results_seen = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  superio_config_register_space DUT (.*);

  scrs_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .port_select_i,
    .write_byte_i, .out_valid_i(out_valid_o), .out_stall_i, .read_byte_i(read_byte_o),
    .unlocked_flag_i(unlocked_flag_o), .errors_o(errors), .pending_o(pending)
  );

  task automatic send_request(input logic k, input logic p, input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    port_select_i <= p;
    write_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_index(input logic [7:0] b);
    send_request(KIND_WRITE, PORT_INDEX, b);
  endtask

  task automatic write_data(input logic [7:0] b);
    send_request(KIND_WRITE, PORT_DATA, b);
  endtask

  task automatic read_reg();
    send_request(KIND_READ, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] pick_index();
    logic [7:0] hot [20] = '{8'h07, 8'h20, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h28,
                             8'h29, 8'h2a, 8'h30, 8'h60, 8'h61, 8'h63, 8'h70, 8'h72,
                             8'he0, 8'hf0, 8'hf3, 8'hf4};
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 2) return IDX_SWRESET;
    if (sel < 60) return hot[$urandom_range(0, 19)];
    if (sel < 75) return 8'($urandom_range(8'hf0, 8'hf7));
    return 8'($urandom_range(0, 255));
  endfunction

  // output side: random stall per result, two long hold-offs
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = (results_seen == 40 || results_seen == 300) ? HOLD_CYCLES : $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (results_seen == 40 || results_seen == 300) n = HOLD_CYCLES;
      repeat (n) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int op;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // locked: reads and ignored data writes, then a broken key
    read_reg();
    write_data(8'hff);
    write_index(IDX_ID_HI);
    read_reg();
    write_index(UNLOCK_KEY);
    write_index(8'h00);
    write_index(UNLOCK_KEY);
    write_index(UNLOCK_KEY);
    // unlocked: device select extremes, masks, write-AND, unknown devices, software reset
    write_index(IDX_DEVSEL);
    write_data(8'd10);
    write_index(8'hf3);
    write_data(8'hff);
    write_data(8'h15);
    read_reg();
    write_index(IDX_DEVSEL);
    write_data(8'd4);
    write_index(8'h30);
    write_data(8'hff);
    read_reg();
    write_index(IDX_DEVSEL);
    write_data(8'hff);
    write_index(8'hf7);
    read_reg();
    write_index(IDX_SWRESET);
    write_data(8'hfe);
    write_data(8'h01);
    read_reg();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      op = $urandom_range(0, 99);
      if (op < 5) begin
        write_index(UNLOCK_KEY);
        write_index(UNLOCK_KEY);
      end else if (op < 12) begin
        write_index(IDX_DEVSEL);
        write_data($urandom_range(0, 7) == 0 ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 12)));
      end else if (op < 40) begin
        write_index(pick_index());
      end else if (op < 70) begin
        write_data(8'($urandom_range(0, 255)));
      end else begin
        read_reg();
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
